>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define SAC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SAC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// shared types, constants and helpers of the cache tag directory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

    localparam int DEF_SETS      = 64;
    localparam int DEF_WAYS      = 8;
    localparam int DEF_ADDR_BITS = 48;

    localparam int STAMP_W   = 48;
    localparam int CNT_W     = 32;
    localparam int OUT_WAY_W = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd3;

    localparam logic [4:0] RST_OFFSET   = 5'd6;
    localparam logic [2:0] RST_SET_BITS = 3'd6;
    localparam logic [3:0] RST_WAYS     = 4'd8;

    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [CNT_W-1:0]   t_count;

    // effective configuration, already clamped
    typedef struct packed {
        logic       policy_lru;
        logic [4:0] offset_bits;
        logic [2:0] set_bits;
        logic [3:0] ways;
    } t_cfg;

    typedef struct packed {
        logic hit;
        logic advance;
    } t_lk_res;

    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sac_req_if.sv
// ----------------------------------------------------------------------------
// sac_req_if
// access request channel: kind and byte address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sac_req_if import sac_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sac_rsp_if.sv
// ----------------------------------------------------------------------------
// sac_rsp_if
// access result channel: hit flag, way and running counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sac_rsp_if import sac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    t_count               hit_count;
    t_count               miss_count;
    t_count               write_count;

    modport source (output valid, output hit, output way, output hit_count,
                    output miss_count, output write_count, input ready);
    modport sink   (input valid, input hit, input way, input hit_count,
                    input miss_count, input write_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sac_cfg.sv
// ----------------------------------------------------------------------------
// sac_cfg
// configuration registers, clamping and address split into set and tag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_cfg import sac_pkg::*; #(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [ADDR_BITS-1:0]  i_addr,
    output t_cfg                  o_cfg,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] o_set,
    output logic [ADDR_BITS-1:0]  o_tag
);

    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LOG2_SETS = $clog2(SETS + 1) - 1;

    logic       r_policy_lru;
    logic [4:0] r_offset_bits;
    logic [2:0] r_set_bits;
    logic [3:0] r_ways;

    logic [ADDR_BITS-1:0] shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_lru  <= 1'b0;
            r_offset_bits <= RST_OFFSET;
            r_set_bits    <= RST_SET_BITS;
            r_ways        <= RST_WAYS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLICY:   r_policy_lru  <= i_cfg_wdata[0];
                CFG_OFFSET:   r_offset_bits <= i_cfg_wdata[4:0];
                CFG_SET_BITS: r_set_bits    <= i_cfg_wdata[2:0];
                CFG_WAYS:     r_ways        <= i_cfg_wdata[3:0];
            endcase
        end
    end

    always_comb begin
        o_cfg.policy_lru  = r_policy_lru;
        o_cfg.offset_bits = r_offset_bits;
        o_cfg.set_bits    = (int'(r_set_bits) > LOG2_SETS) ? 3'(LOG2_SETS) : r_set_bits;
        if (r_ways == 4'd0) begin
            o_cfg.ways = 4'd1;
        end else if (int'(r_ways) > WAYS) begin
            o_cfg.ways = 4'(WAYS);
        end else begin
            o_cfg.ways = r_ways;
        end
    end

    assign shifted = i_addr >> o_cfg.offset_bits;
    assign o_set   = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << o_cfg.set_bits);
    assign o_tag   = shifted >> o_cfg.set_bits;

endmodule

`default_nettype wire

>>> hw/rtl/sac_tag_ram.sv
// ----------------------------------------------------------------------------
// sac_tag_ram
// one row per set holding valid, tag and stamp of every way; clears after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_tag_ram import sac_pkg::*; #(
    parameter int SETS  = DEF_SETS,
    parameter int ROW_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] i_rd_addr,
    output logic [ROW_W-1:0]      o_rd_data,
    input  logic                  i_wr_en,
    input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]      i_wr_data,
    output logic                  o_clr_busy
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

    logic [ROW_W-1:0] mem [SETS];

    logic             r_clr_busy;
    logic [SET_W-1:0] r_clr_idx;
    logic             we;
    logic [SET_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;

    // clear sweep, one row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == SET_W'(SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
        end
    end

    assign we    = r_clr_busy || i_wr_en;
    assign waddr = r_clr_busy ? r_clr_idx : i_wr_addr;
    assign wdata = r_clr_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

>>> hw/rtl/sac_lookup.sv
// ----------------------------------------------------------------------------
// sac_lookup
// way match, first free way, oldest stamp victim and updated set row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_lookup import sac_pkg::*; #(
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  t_cfg                                   i_cfg,
    input  logic [WAYS*(1+ADDR_BITS+STAMP_W)-1:0]  i_row,
    input  logic [ADDR_BITS-1:0]                   i_tag,
    input  t_stamp                                 i_stamp_next,
    output t_lk_res                                o_res,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_way,
    output logic [WAYS*(1+ADDR_BITS+STAMP_W)-1:0]  o_row
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int P     = 1 << WAY_W;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] tag;
        t_stamp               stamp;
    } t_entry;

    t_entry [WAYS-1:0] ents;
    t_entry [WAYS-1:0] new_ents;

    logic [WAYS-1:0]  in_use;
    logic [WAYS-1:0]  sel;
    logic             found;
    logic [WAY_W-1:0] first;

    t_stamp           nd_stamp [2*P];
    logic             nd_pres  [2*P];
    logic [WAY_W-1:0] nd_idx   [2*P];

    assign ents = i_row;

    // first way that is free or matches
    always_comb begin
        found = 1'b0;
        first = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            in_use[w] = (w < int'(i_cfg.ways));
            sel[w]    = in_use[w] && (!ents[w].valid || (ents[w].tag == i_tag));
            if (sel[w]) begin
                found = 1'b1;
                first = WAY_W'(w);
            end
        end
    end

    // oldest stamp tree, ties go to the higher way
    always_comb begin
        for (int n = 0; n < 2 * P; n++) begin
            nd_stamp[n] = '0;
            nd_pres[n]  = 1'b0;
            nd_idx[n]   = '0;
        end
        for (int w = 0; w < WAYS; w++) begin
            nd_stamp[P + w] = ents[w].stamp;
            nd_pres[P + w]  = in_use[w];
            nd_idx[P + w]   = WAY_W'(w);
        end
        for (int i = P - 1; i >= 1; i--) begin
            if (!nd_pres[2 * i]
                    || (nd_pres[2 * i + 1] && (nd_stamp[2 * i + 1] <= nd_stamp[2 * i]))) begin
                nd_stamp[i] = nd_stamp[2 * i + 1];
                nd_pres[i]  = nd_pres[2 * i + 1];
                nd_idx[i]   = nd_idx[2 * i + 1];
            end else begin
                nd_stamp[i] = nd_stamp[2 * i];
                nd_pres[i]  = nd_pres[2 * i];
                nd_idx[i]   = nd_idx[2 * i];
            end
        end
    end

    always_comb begin
        o_res.hit     = found && ents[first].valid;
        o_res.advance = !o_res.hit || i_cfg.policy_lru;
        o_way         = found ? first : nd_idx[1];
        new_ents      = ents;
        if (o_res.advance) begin
            new_ents[o_way].valid = 1'b1;
            new_ents[o_way].tag   = i_tag;
            new_ents[o_way].stamp = i_stamp_next;
        end
    end

    assign o_row = new_ents;

endmodule

`default_nettype wire

>>> hw/rtl/set_assoc_cache_fifo_lru_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lru_unit
// tag directory of a set-associative cache with fifo or lru replacement
// ----------------------------------------------------------------------------
// usage:
//   i_req carries one request (kind, address); o_rsp returns one result per
//   request with hit, way and the saturating hit, miss and write counts.
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata
//   only while the unit is idle, by the user; the unit does not enforce it.
// operation:
//   a request reads its set row from the tag ram at the accept edge; the
//   lookup state then compares tags, picks the victim and writes the row back
//   while loading the result register. a new request is accepted only after
//   the read-modify-write of the last request's set row is done.
// reset:
//   counters and stamp counter clear, registers take their reset values, and
//   the tag ram is swept clear, all SETS rows (64 by default), before the
//   first request is accepted.
// stall:
//   a held result blocks the write-back of the following request until
//   o_rsp.ready; one request may be accepted while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_fifo_lru_unit import sac_pkg::*; #(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    sac_req_if.sink               i_req,
    sac_rsp_if.source             o_rsp
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * (1 + ADDR_BITS + STAMP_W);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    t_cfg                 cfg;
    logic [SET_W-1:0]     split_set;
    logic [ADDR_BITS-1:0] split_tag;
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     wb_row;
    logic                 clr_busy;
    t_lk_res              lk_res;
    logic [WAY_W-1:0]     lk_way;

    logic                 r_state, n_state;
    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic                 r_kind;
    t_stamp               r_stamp, n_stamp;
    t_count               r_hits, n_hits;
    t_count               r_misses, n_misses;
    t_count               r_writes, n_writes;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_hit;
    logic [OUT_WAY_W-1:0] r_out_way;

    logic                 accept;
    logic                 fire;
    t_stamp               stamp_inc;

    sac_cfg #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_addr      (i_req.address),
        .o_cfg       (cfg),
        .o_set       (split_set),
        .o_tag       (split_tag)
    );

    sac_tag_ram #(
        .SETS  (SETS),
        .ROW_W (ROW_W)
    ) u_tag_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (split_set),
        .o_rd_data  (rd_row),
        .i_wr_en    (fire),
        .i_wr_addr  (r_set),
        .i_wr_data  (wb_row),
        .o_clr_busy (clr_busy)
    );

    sac_lookup #(
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_lookup (
        .i_cfg        (cfg),
        .i_row        (rd_row),
        .i_tag        (r_tag),
        .i_stamp_next (stamp_inc),
        .o_res        (lk_res),
        .o_way        (lk_way),
        .o_row        (wb_row)
    );

    assign i_req.ready = (r_state == ST_IDLE) && !clr_busy;
    assign accept      = i_req.valid && i_req.ready;
    assign fire        = (r_state == ST_LOOKUP) && (!r_out_valid || o_rsp.ready);
    assign stamp_inc   = r_stamp + STAMP_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_LOOKUP;
            ST_LOOKUP: if (fire) n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_stamp     = r_stamp;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_writes    = r_writes;
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (fire) begin
            n_out_valid = 1'b1;
            if (lk_res.advance) begin
                n_stamp = stamp_inc;
            end
            if (lk_res.hit) begin
                n_hits = sat_inc(r_hits);
            end else begin
                n_misses = sat_inc(r_misses);
            end
            if (r_kind) begin
                n_writes = sat_inc(r_writes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stamp     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_writes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stamp     <= n_stamp;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_writes    <= n_writes;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set  <= split_set;
            r_tag  <= split_tag;
            r_kind <= i_req.kind;
        end
        if (fire) begin
            r_out_hit <= lk_res.hit;
            r_out_way <= OUT_WAY_W'(lk_way);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.way         = r_out_way;
    assign o_rsp.hit_count   = r_hits;
    assign o_rsp.miss_count  = r_misses;
    assign o_rsp.write_count = r_writes;

    `SAC_ASSERT(a_accept_to_lookup, i_clk, i_rst_n, accept |=> (r_state == ST_LOOKUP), "request accepted but no lookup followed")
    `SAC_ASSERT_NR(a_no_accept_clear, i_clk, clr_busy |-> !i_req.ready, "request ready during tag ram clear")
    `SAC_ASSERT(a_miss_stamp, i_clk, i_rst_n, (fire && !lk_res.hit) |=> (r_stamp == $past(r_stamp) + STAMP_W'(1)), "fill did not advance stamp counter")
    `SAC_ASSERT(a_way_in_use, i_clk, i_rst_n, fire |-> (int'(lk_way) < int'(cfg.ways)), "selected way outside ways in use")

endmodule

`default_nettype wire

>>> dv/sac_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_tb_pkg
// access kinds shared by the cache directory stimulus and its checker
// ----------------------------------------------------------------------------

package sac_tb_pkg;

    typedef enum logic {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } t_access;

endpackage

>>> dv/cache_dir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_dir_checker
// watches the request, result and register ports of the cache tag directory,
// keeps its own copy of the tags, stamps and counters, works out the hit,
// way and counts of every accepted request and compares them in order with
// the results the directory returns; hands the failure and backlog counts up
// ----------------------------------------------------------------------------

module cache_dir_checker import sac_pkg::*, sac_tb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    sac_req_if                    i_req,
    sac_rsp_if                    i_rsp,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int LINES        = DEF_SETS * DEF_WAYS;
    localparam int SET_BITS_MAX = $clog2(DEF_SETS);

    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        t_count               hits;
        t_count               misses;
        t_count               writes;
    } t_lookup;

    bit                       line_valid [LINES];
    logic [DEF_ADDR_BITS-1:0] line_tag   [LINES];
    t_stamp                   line_age   [LINES];
    t_stamp                   age_clock;
    t_count                   n_hits;
    t_count                   n_misses;
    t_count                   n_writes;

    logic       lru_mode;
    logic [4:0] blk_shift;
    logic [2:0] idx_bits;
    logic [3:0] ways_cfg;

    t_lookup lookups_due [$];

    task automatic lookup_and_fill(input t_access acc, input logic [DEF_ADDR_BITS-1:0] addr,
                                   output t_lookup res);
        int                       sb;
        int                       nw;
        int                       row;
        int                       pick;
        bit                       hit;
        bit                       placed;
        logic [DEF_ADDR_BITS-1:0] tag;
        sb  = (idx_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(idx_bits);
        nw  = (ways_cfg == 0) ? 1 : ((ways_cfg > DEF_WAYS) ? DEF_WAYS : int'(ways_cfg));
        row = int'((addr >> blk_shift) & ((DEF_ADDR_BITS'(1) << sb) - 1)) * DEF_WAYS;
        tag = addr >> (blk_shift + sb);
        hit    = 1'b0;
        placed = 1'b0;
        pick   = 0;
        if (acc == ACC_WRITE && n_writes != '1) n_writes++;
        for (int w = 0; w < nw && !placed; w++) begin
            if (!line_valid[row + w]) begin
                age_clock++;
                line_valid[row + w] = 1'b1;
                line_tag[row + w]   = tag;
                line_age[row + w]   = age_clock;
                pick   = w;
                placed = 1'b1;
            end else if (line_tag[row + w] == tag) begin
                if (lru_mode) begin
                    age_clock++;
                    line_age[row + w] = age_clock;
                end
                pick   = w;
                hit    = 1'b1;
                placed = 1'b1;
            end
        end
        // set full: oldest stamp goes, ties to the highest way
        if (!placed) begin
            for (int w = 0; w < nw; w++) begin
                if (line_age[row + w] <= line_age[row + pick]) pick = w;
            end
            age_clock++;
            line_tag[row + pick] = tag;
            line_age[row + pick] = age_clock;
        end
        if (hit) begin
            if (n_hits != '1) n_hits++;
        end else if (n_misses != '1) begin
            n_misses++;
        end
        res = '{hit, OUT_WAY_W'(pick), n_hits, n_misses, n_writes};
    endtask

    function automatic int field_bad(string name, longint unsigned want, longint unsigned got);
        if (want == got) return 0;
        $display("%0t ns %s mismatch: expected %0h actual %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_lookup want;
        t_lookup fresh;
        if (!i_rst_n) begin
            foreach (line_valid[k]) line_valid[k] = 1'b0;
            age_clock = '0;
            n_hits    = '0;
            n_misses  = '0;
            n_writes  = '0;
            lru_mode  = 1'b0;
            blk_shift = RST_OFFSET;
            idx_bits  = RST_SET_BITS;
            ways_cfg  = RST_WAYS;
            lookups_due.delete();
            o_errors  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY:   lru_mode  = i_cfg_wdata[0];
                    CFG_OFFSET:   blk_shift = i_cfg_wdata[4:0];
                    CFG_SET_BITS: idx_bits  = i_cfg_wdata[2:0];
                    CFG_WAYS:     ways_cfg  = i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (lookups_due.size() == 0) begin
                    $display("%0t ns unexpected result: expected none actual hit %0b way %0d",
                             $time, i_rsp.hit, i_rsp.way);
                    o_errors++;
                end else begin
                    want = lookups_due.pop_front();
                    o_errors += field_bad("hit", want.hit, i_rsp.hit);
                    o_errors += field_bad("way", want.way, i_rsp.way);
                    o_errors += field_bad("hit_count", want.hits, i_rsp.hit_count);
                    o_errors += field_bad("miss_count", want.misses, i_rsp.miss_count);
                    o_errors += field_bad("write_count", want.writes, i_rsp.write_count);
                end
            end
            if (i_req.valid && i_req.ready) begin
                lookup_and_fill(t_access'(i_req.kind), i_req.address, fresh);
                lookups_due.push_back(fresh);
            end
        end
        o_pending = lookups_due.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the cache tag directory: a directed fill and eviction run at
// the reset geometry, then random request streams over both replacement
// policies, block sizes, set counts and associativities, with random gaps on
// both channels and one long result stall; the checker judges the results
// ----------------------------------------------------------------------------

module tb;

    import sac_pkg::*;
    import sac_tb_pkg::*;

    typedef struct {
        logic lru;
        int   off;
        int   sb;
        int   ways;
    } t_setup;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    n_errors;
    int                    n_pending;
    bit                    send_gaps;
    bit                    take_gaps;
    int                    n_taken;

    t_setup setups [9] = '{
        '{1'b1,  6, 6, 8},
        '{1'b0,  0, 0, 1},
        '{1'b1, 16, 6, 8},
        '{1'b1, 31, 7, 0},
        '{1'b0,  4, 2, 15},
        '{1'b1,  0, 3, 4},
        '{1'b0, 12, 1, 2},
        '{1'b1,  3, 6, 8},
        '{1'b0,  9, 5, 9}
    };

    logic [DEF_ADDR_BITS-1:0] tag_pool [16];
    int                       pool_n;
    int                       hot_base;
    int                       hot_span;
    int                       cur_off;
    int                       cur_sb;

    sac_req_if #(.ADDR_BITS(DEF_ADDR_BITS)) req_if ();
    sac_rsp_if                              rsp_if ();

    set_assoc_cache_fifo_lru_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    cache_dir_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off
    initial begin
        int hold;
        rsp_if.ready = 1'b0;
        n_taken   = 0;
        take_gaps = 1'b1;
        forever begin
            @(negedge clk);
            if (n_taken == 300) begin
                rsp_if.ready <= 1'b0;
                repeat (150) @(negedge clk);
            end
            if (n_taken % 64 == 0) take_gaps = ($urandom_range(0, 2) != 0);
            hold = take_gaps ? $urandom_range(0, 15) : 0;
            if (hold > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
            n_taken++;
        end
    end

    task automatic send_access(input t_access acc, input logic [DEF_ADDR_BITS-1:0] addr);
        int gap;
        gap = send_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.kind    <= acc;
        req_if.address <= addr;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge clk);
    endtask

    task automatic begin_phase(input t_setup s);
        int nw;
        write_reg(CFG_POLICY, s.lru);
        write_reg(CFG_OFFSET, s.off);
        write_reg(CFG_SET_BITS, s.sb);
        write_reg(CFG_WAYS, s.ways);
        cfg_we <= 1'b0;
        cur_off = s.off;
        cur_sb  = (s.sb > 6) ? 6 : s.sb;
        nw      = (s.ways == 0) ? 1 : ((s.ways > DEF_WAYS) ? DEF_WAYS : s.ways);
        pool_n  = nw + $urandom_range(1, 4);
        for (int k = 0; k < 16; k++) begin
            tag_pool[k] = ($urandom_range(0, 3) == 0) ? DEF_ADDR_BITS'(k)
                                                      : DEF_ADDR_BITS'({$urandom, $urandom});
        end
        hot_base  = $urandom_range(0, 63);
        hot_span  = $urandom_range(0, 3);
        send_gaps = ($urandom_range(0, 3) != 0);
    endtask

    // mostly a few tags on a few hot sets, some noise
    function automatic logic [DEF_ADDR_BITS-1:0] pick_address();
        logic [DEF_ADDR_BITS-1:0] noise;
        logic [DEF_ADDR_BITS-1:0] set_idx;
        logic [DEF_ADDR_BITS-1:0] tag;
        noise = DEF_ADDR_BITS'({$urandom, $urandom});
        if ($urandom_range(0, 9) == 0) return noise;
        set_idx = ($urandom_range(0, 3) == 0) ? DEF_ADDR_BITS'($urandom)
                                              : DEF_ADDR_BITS'(hot_base + $urandom_range(0, hot_span));
        set_idx &= (DEF_ADDR_BITS'(1) << cur_sb) - 1;
        tag = tag_pool[$urandom_range(0, pool_n - 1)];
        return (tag << (cur_off + cur_sb)) | (set_idx << cur_off)
             | (noise & ((DEF_ADDR_BITS'(1) << cur_off) - 1));
    endfunction

    initial begin
        t_access acc;
        req_if.valid   = 1'b0;
        req_if.kind    = ACC_READ;
        req_if.address = '0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_POLICY;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        send_gaps      = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: tag starts at bit 12, fifo
        send_access(ACC_READ, '0);
        send_access(ACC_WRITE, '0);
        send_access(ACC_READ, '1);
        send_access(ACC_WRITE, '1);
        for (int t = 1; t < 8; t++) send_access(ACC_READ, DEF_ADDR_BITS'(t) << 12);
        send_access(ACC_WRITE, DEF_ADDR_BITS'(8) << 12);
        send_access(ACC_READ, (DEF_ADDR_BITS'(1) << 12) | DEF_ADDR_BITS'('h3f));
        send_access(ACC_READ, DEF_ADDR_BITS'(9) << 12);
        send_access(ACC_READ, '0);
        send_access(ACC_WRITE, DEF_ADDR_BITS'('h8000_0000_5000));
        drain();

        foreach (setups[p]) begin
            begin_phase(setups[p]);
            repeat (130) begin
                acc = t_access'($urandom_range(0, 1));
                send_access(acc, pick_address());
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
